[sv/itoa_pkg.sv]
package itoa_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int NUM_DIGITS_DEF  = 10;

    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    localparam logic [7:0] DIGIT_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_CONV,
        CTL_EMIT
    } ctl_state_t;

    typedef enum logic [1:0] {
        EMIT_IDLE,
        EMIT_SKIP,
        EMIT_SIGN,
        EMIT_DIGIT
    } emit_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } conv_stat_t;

endpackage

[sv/itoa_if.sv]
interface itoa_in_if #(
    parameter int W = itoa_pkg::VALUE_WIDTH_DEF
);
    logic         valid;
    logic         ready;
    logic [W-1:0] value;
    logic         func;

    modport source (output valid, value, func, input ready);
    modport sink   (input valid, value, func, output ready);
endinterface

interface itoa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, character, last, input ready);
    modport sink   (input valid, character, last, output ready);
endinterface

[sv/integer_to_ascii_dec_hex.sv]
// Converts one VALUE_WIDTH-bit operand per transaction to ASCII text, one character per
// output transaction, most significant digit first, no leading zeros, last set on the
// final character. func = 0 reads the operand as two's complement and prints, for a
// negative one, '-' and then the decimal magnitude; func = 1 prints it unsigned in
// lower-case hex. A decimal conversion runs a shift-and-add-3 loop over the VALUE_WIDTH
// operand bits, while a hex one loads its digits directly; the emitter then drops each
// leading zero digit slot, leaves that scan and sends each character in turn, holding
// while the output register is still full and not taken.
// A new operand is taken only once the previous one has been fully handed to the output
// register; the final character may still be waiting there.
module integer_to_ascii_dec_hex #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    itoa_in_if.sink    in_ch,
    itoa_out_if.source out_ch
);

    localparam int DEC_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
    localparam int NUM_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;

    itoa_pkg::ctl_state_t state_reg, state_next;

    logic                    neg_reg, neg_next;
    logic                    accept;
    logic                    in_neg;
    logic [VALUE_WIDTH-1:0]  in_mag;
    logic                    emit_start;
    logic                    emit_busy;
    itoa_pkg::conv_stat_t    conv_stat;
    logic [NUM_DIGITS*4-1:0] digits;

    assign accept = in_ch.valid && in_ch.ready;
    assign in_neg = !in_ch.func && in_ch.value[VALUE_WIDTH-1];
    assign in_mag = in_neg ? (~in_ch.value + VALUE_WIDTH'(1)) : in_ch.value;

    always_comb
    begin
        state_next  = state_reg;
        neg_next    = neg_reg;
        in_ch.ready = 1'b0;
        emit_start  = 1'b0;
        case (state_reg)
            itoa_pkg::CTL_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    neg_next   = in_neg;
                    state_next = itoa_pkg::CTL_CONV;
                end
            end
            itoa_pkg::CTL_CONV:
            begin
                if (conv_stat.done)
                begin
                    emit_start = 1'b1;
                    state_next = itoa_pkg::CTL_EMIT;
                end
            end
            itoa_pkg::CTL_EMIT:
            begin
                if (!emit_busy)
                    state_next = itoa_pkg::CTL_IDLE;
            end
            default:
            begin
                state_next = itoa_pkg::CTL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= itoa_pkg::CTL_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
    end

    itoa_dabble #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NUM_DIGITS  (NUM_DIGITS)
    ) u_dabble (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .hex    (in_ch.func),
        .mag    (in_mag),
        .stat   (conv_stat),
        .digits (digits)
    );

    itoa_emit #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (emit_start),
        .neg    (neg_reg),
        .digits (digits),
        .busy   (emit_busy),
        .out_ch (out_ch)
    );

endmodule

[sv/itoa_dabble.sv]
module itoa_dabble #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF,
    parameter int NUM_DIGITS  = itoa_pkg::NUM_DIGITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      hex,
    input  logic [VALUE_WIDTH-1:0]    mag,
    output itoa_pkg::conv_stat_t      stat,
    output logic [NUM_DIGITS*4-1:0]   digits
);

    localparam int DIG_BITS = NUM_DIGITS * 4;
    localparam int CNT_W    = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [DIG_BITS-1:0]    bcd_reg, bcd_next;
    logic [DIG_BITS-1:0]    bcd_adj;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   run_reg, run_next;
    logic                   done_reg, done_next;

    // add 3 to every bcd digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] inside {[4'd5:4'd15]})
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            if (hex)
            begin
                bcd_next  = DIG_BITS'(mag);
                done_next = 1'b1;
            end
            else
            begin
                bin_next = mag;
                bcd_next = '0;
                cnt_next = CNT_W'(VALUE_WIDTH);
                run_next = 1'b1;
            end
        end
        else if (run_reg)
        begin
            bcd_next = {bcd_adj[DIG_BITS-2:0], bin_reg[VALUE_WIDTH-1]};
            bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
    end

    assign stat.busy = run_reg;
    assign stat.done = done_reg;
    assign digits    = bcd_reg;

endmodule

[sv/itoa_emit.sv]
module itoa_emit #(
    parameter int NUM_DIGITS = itoa_pkg::NUM_DIGITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    neg,
    input  logic [NUM_DIGITS*4-1:0] digits,
    output logic                    busy,
    itoa_out_if.source              out_ch
);

    localparam int DIG_BITS = NUM_DIGITS * 4;
    localparam int CNT_W    = $clog2(NUM_DIGITS + 1);

    itoa_pkg::emit_state_t state_reg, state_next;

    logic [DIG_BITS-1:0] dig_reg, dig_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                neg_reg, neg_next;
    logic [7:0]          char_reg, char_next;
    logic                last_reg, last_next;
    logic                valid_reg, valid_next;
    logic                out_free;
    logic [3:0]          top_nib;

    assign out_free = !valid_reg || out_ch.ready;
    assign top_nib  = dig_reg[DIG_BITS-1 -: 4];

    always_comb
    begin
        state_next = state_reg;
        dig_next   = dig_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        valid_next = valid_reg && !out_ch.ready;
        case (state_reg)
            itoa_pkg::EMIT_IDLE:
            begin
                if (start)
                begin
                    dig_next   = digits;
                    cnt_next   = CNT_W'(NUM_DIGITS);
                    neg_next   = neg;
                    state_next = itoa_pkg::EMIT_SKIP;
                end
            end
            // drop leading zeros, keeping at least one digit
            itoa_pkg::EMIT_SKIP:
            begin
                if (top_nib == 4'd0 && cnt_reg != CNT_W'(1))
                begin
                    dig_next = {dig_reg[DIG_BITS-5:0], 4'h0};
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else if (neg_reg)
                    state_next = itoa_pkg::EMIT_SIGN;
                else
                    state_next = itoa_pkg::EMIT_DIGIT;
            end
            itoa_pkg::EMIT_SIGN:
            begin
                if (out_free)
                begin
                    char_next  = itoa_pkg::CHAR_MINUS;
                    last_next  = 1'b0;
                    valid_next = 1'b1;
                    state_next = itoa_pkg::EMIT_DIGIT;
                end
            end
            itoa_pkg::EMIT_DIGIT:
            begin
                if (out_free)
                begin
                    char_next  = itoa_pkg::DIGIT_CHARS[top_nib];
                    last_next  = (cnt_reg == CNT_W'(1));
                    valid_next = 1'b1;
                    dig_next   = {dig_reg[DIG_BITS-5:0], 4'h0};
                    cnt_next   = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                        state_next = itoa_pkg::EMIT_IDLE;
                end
            end
            default:
            begin
                state_next = itoa_pkg::EMIT_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itoa_pkg::EMIT_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign busy             = (state_reg != itoa_pkg::EMIT_IDLE);
    assign out_ch.valid     = valid_reg;
    assign out_ch.character = char_reg;
    assign out_ch.last      = last_reg;

endmodule

[dv/tb_integer_to_ascii_dec_hex.sv]
`timescale 1ns / 100ps

module tb_integer_to_ascii_dec_hex;

    localparam logic FUNC_DEC = 1'b0;
    localparam logic FUNC_HEX = 1'b1;
    localparam int TEXT_BYTES = 11;
    localparam logic [8*TEXT_BYTES-1:0] NO_TEXT = '0;
    localparam int N_ROWS = 24;
    localparam int SETTLE_CYCLES = 100;

    typedef struct packed {
        logic [31:0]               value;
        logic                      func;
        logic [8*TEXT_BYTES-1:0]   text;
    } text_row_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } char_rec_t;

    // text column is empty where the predictor supplies the expected characters
    text_row_t directed_rows [N_ROWS] = '{
        '{32'h0000_0000, FUNC_DEC, "0"},
        '{32'h0000_0000, FUNC_HEX, "0"},
        '{32'h0000_0001, FUNC_DEC, "1"},
        '{32'hffff_ffff, FUNC_DEC, "-1"},
        '{32'h7fff_ffff, FUNC_DEC, "2147483647"},
        '{32'h8000_0000, FUNC_DEC, "-2147483648"},
        '{32'h8000_0001, FUNC_DEC, "-2147483647"},
        '{32'hffff_ffff, FUNC_HEX, "ffffffff"},
        '{32'h8000_0000, FUNC_HEX, "80000000"},
        '{32'h7fff_ffff, FUNC_HEX, "7fffffff"},
        '{32'h0000_000f, FUNC_HEX, "f"},
        '{32'h0000_0009, FUNC_DEC, "9"},
        '{32'h0000_000a, FUNC_DEC, "10"},
        '{32'h0123_abcd, FUNC_HEX, "123abcd"},
        '{32'hdead_beef, FUNC_HEX, "deadbeef"},
        '{32'h3b9a_ca00, FUNC_DEC, NO_TEXT},
        '{32'hc465_3600, FUNC_DEC, NO_TEXT},
        '{32'h0000_0010, FUNC_HEX, "10"},
        '{32'h0000_ffff, FUNC_HEX, "ffff"},
        '{32'h0000_03e8, FUNC_DEC, NO_TEXT},
        '{32'hffff_fc18, FUNC_DEC, NO_TEXT},
        '{32'h1234_5678, FUNC_DEC, NO_TEXT},
        '{32'h5555_5555, FUNC_HEX, NO_TEXT},
        '{32'haaaa_aaaa, FUNC_DEC, NO_TEXT}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic [8*TEXT_BYTES-1:0] row_text;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int n_errors;
    int n_dec_items;
    int n_hex_items;
    int n_neg_items;
    int n_chars;

    char_rec_t pending_chars [$];

    itoa_in_if #(.W(32)) in_ch ();
    itoa_out_if          out_ch ();

    integer_to_ascii_dec_hex #(
        .VALUE_WIDTH (32)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        n_errors++;
    endtask

    function automatic void queue_typed_text(input logic [8*TEXT_BYTES-1:0] text);
        char_rec_t rec;
        int top;
        top = -1;
        for (int i = 0; i < TEXT_BYTES; i++)
        begin
            if (text[8*i +: 8] != 8'h00)
                top = i;
        end
        for (int i = top; i >= 0; i--)
        begin
            rec.character = text[8*i +: 8];
            rec.last = (i == 0);
            pending_chars.push_back(rec);
        end
    endfunction

    function automatic void predict_text(input logic [31:0] operand, input logic mode);
        logic [7:0] rev [TEXT_BYTES];
        logic [32:0] mag;
        logic neg;
        int nd;
        char_rec_t rec;
        neg = (mode == FUNC_DEC) && operand[31];
        mag = {1'b0, operand};
        // magnitude kept one bit wider so the most negative value survives
        if (neg)
            mag = 33'h1_0000_0000 - mag;
        nd = 0;
        do
        begin
            if (mode == FUNC_HEX)
            begin
                rev[nd] = itoa_pkg::DIGIT_CHARS[mag[3:0]];
                mag = mag >> 4;
            end
            else
            begin
                rev[nd] = itoa_pkg::DIGIT_CHARS[4'(mag % 10)];
                mag = mag / 10;
            end
            nd++;
        end
        while (mag != 0);
        if (neg)
        begin
            rec.character = itoa_pkg::CHAR_MINUS;
            rec.last = 1'b0;
            pending_chars.push_back(rec);
        end
        for (int k = nd - 1; k >= 0; k--)
        begin
            rec.character = rev[k];
            rec.last = (k == 0);
            pending_chars.push_back(rec);
        end
    endfunction

    function automatic logic [31:0] random_operand();
        logic [31:0] v;
        int unsigned p;
        case ($urandom_range(0, 7))
            0, 1, 2: v = $urandom;
            3: v = $urandom_range(0, 20);
            4: v = 32'h0 - $urandom_range(1, 20);
            5:
            begin
                p = 1;
                repeat ($urandom_range(0, 9)) p = p * 10;
                v = p - 1 + $urandom_range(0, 2);
                if ($urandom_range(0, 1) == 1)
                    v = 32'h0 - v;
            end
            6:
            begin
                case ($urandom_range(0, 2))
                    0: v = 32'h8000_0000 + $urandom_range(0, 3);
                    1: v = 32'h7fff_ffff - $urandom_range(0, 3);
                    default: v = 32'hffff_ffff - $urandom_range(0, 3);
                endcase
            end
            default:
            begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1)
                    v = 32'h0 - v;
            end
        endcase
        return v;
    endfunction

    always @(negedge clk)
    begin
        out_ch.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : monitor
        char_rec_t want;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.func == FUNC_HEX)
                    n_hex_items++;
                else
                    n_dec_items++;
                if (in_ch.func == FUNC_DEC && in_ch.value[31])
                    n_neg_items++;
                if (row_text != NO_TEXT)
                    queue_typed_text(row_text);
                else
                    predict_text(in_ch.value, in_ch.func);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_chars.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                              out_ch.character, out_ch.last));
                end
                else
                begin
                    want = pending_chars.pop_front();
                    n_chars++;
                    if (out_ch.character !== want.character)
                        report_mismatch($sformatf("character 0x%02h, want 0x%02h",
                                                  out_ch.character, want.character));
                    if (out_ch.last !== want.last)
                        report_mismatch($sformatf("last %0b on 0x%02h, want %0b",
                                                  out_ch.last, want.character, want.last));
                end
            end
        end
    end

    task automatic send_item(input logic [31:0] v, input logic f,
                             input logic [8*TEXT_BYTES-1:0] txt);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        in_ch.func  <= f;
        row_text    <= txt;
        do
            @(posedge clk);
        while (!(in_ch.valid && in_ch.ready));
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_random(input int count);
        logic [31:0] v;
        logic f;
        for (int i = 0; i < count; i++)
        begin
            v = random_operand();
            f = ($urandom_range(0, 1) == 1) ? FUNC_HEX : FUNC_DEC;
            send_item(v, f, NO_TEXT);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.value = '0;
        in_ch.func = FUNC_DEC;
        row_text = NO_TEXT;
        n_errors = 0;
        n_dec_items = 0;
        n_hex_items = 0;
        n_neg_items = 0;
        n_chars = 0;
        send_idle_pct = 19;
        recv_idle_pct = 51;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < N_ROWS; r++)
            send_item(directed_rows[r].value, directed_rows[r].func, directed_rows[r].text);
        drain_results();

        run_random(65);
        drain_results();

        send_idle_pct = 51;
        recv_idle_pct = 19;
        run_random(65);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(66);
        drain_results();

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("ran %0d decimal (%0d negative) and %0d hex conversions, %0d characters checked",
                 n_dec_items, n_neg_items, n_hex_items, n_chars);
        $display("stalls on sender and receiver in both proportions, then a stall-free stretch");
        if (n_errors == 0 && pending_chars.size() == 0)
            $display("** integer_to_ascii_dec_hex: PASSED **");
        else
            $display("** integer_to_ascii_dec_hex: FAILED **");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d characters outstanding", pending_chars.size());
        $display("** integer_to_ascii_dec_hex: FAILED **");
        $finish;
    end

endmodule

[sim.f]
sv/itoa_pkg.sv
sv/itoa_if.sv
sv/itoa_dabble.sv
sv/itoa_emit.sv
sv/integer_to_ascii_dec_hex.sv
dv/tb_integer_to_ascii_dec_hex.sv
